FILE: hdl/jcsg_pkg.sv
// Shared types, constants and reset values for the joint command safety gate.
`default_nettype none
package jcsg_pkg;

  localparam int JOINTS = 4;
  localparam int ANGLE_W = 16;
  localparam int PACK_W = 64;
  localparam int MOTION_W = 16;
  localparam int TICK_W = 32;
  localparam int COUNT_W = 32;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [PACK_W-1:0] MIN_ANGLES_RST = 64'h8000_8000_8000_8000;
  localparam logic [PACK_W-1:0] MAX_ANGLES_RST = 64'h7FFF_7FFF_7FFF_7FFF;
  localparam logic [MOTION_W-1:0] MIN_MOTION_RST = 16'h0000;
  localparam logic [MOTION_W-1:0] MAX_MOTION_RST = 16'hFFFF;

  // Register indexes (byte address = 8 * index)
  typedef enum logic [2:0] {
    REG_MIN_ANGLES   = 3'd0,
    REG_MAX_ANGLES   = 3'd1,
    REG_MIN_MOTION   = 3'd2,
    REG_MAX_MOTION   = 3'd3,
    REG_DUP_EPSILON  = 3'd4,
    REG_MIN_INTERVAL = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_BAD_ANGLE    = 3'd1,
    ST_BAD_DURATION = 3'd2,
    ST_DUPLICATE    = 3'd3,
    ST_RATE         = 3'd4,
    ST_LINK         = 3'd5
  } status_t;

  typedef struct packed {
    logic [PACK_W-1:0]   min_angles;
    logic [PACK_W-1:0]   max_angles;
    logic [MOTION_W-1:0] min_motion;
    logic [MOTION_W-1:0] max_motion;
    logic [ANGLE_W-1:0]  dup_epsilon;
    logic [TICK_W-1:0]   min_interval;
  } cfg_t;

  typedef struct packed {
    logic [PACK_W-1:0]   angles;
    logic [MOTION_W-1:0] motion;
    logic [TICK_W-1:0]   now;
    logic                link_ready;
  } cmd_t;

  typedef struct packed {
    logic                has_last;
    logic [PACK_W-1:0]   angles;
    logic [MOTION_W-1:0] motion;
    logic [TICK_W-1:0]   last_time;
  } hist_t;

  typedef struct packed {
    logic [COUNT_W-1:0] attempted;
    logic [COUNT_W-1:0] accepted;
    logic [COUNT_W-1:0] rejected;
    logic [COUNT_W-1:0] link_fail;
  } counts_t;

  // Signed lane j of a packed angle word
  function automatic logic signed [ANGLE_W-1:0] lane(input logic [PACK_W-1:0] word,
                                                     input int j);
    lane = $signed(word[j*ANGLE_W +: ANGLE_W]);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/jcsg_cfg_regs.sv
// APB-style configuration register file for the safety gate limits.
`default_nettype none
module jcsg_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [jcsg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [jcsg_pkg::DATA_W-1:0] pwdata,
  output logic      [jcsg_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output jcsg_pkg::cfg_t                 cfg
);
  import jcsg_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:3];

  // Write decode, values masked to register widths
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MIN_ANGLES:   cfg_nxt.min_angles   = pwdata;
        REG_MAX_ANGLES:   cfg_nxt.max_angles   = pwdata;
        REG_MIN_MOTION:   cfg_nxt.min_motion   = pwdata[MOTION_W-1:0];
        REG_MAX_MOTION:   cfg_nxt.max_motion   = pwdata[MOTION_W-1:0];
        REG_DUP_EPSILON:  cfg_nxt.dup_epsilon  = pwdata[ANGLE_W-1:0];
        REG_MIN_INTERVAL: cfg_nxt.min_interval = pwdata[TICK_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_angles   <= MIN_ANGLES_RST;
      cfg_r.max_angles   <= MAX_ANGLES_RST;
      cfg_r.min_motion   <= MIN_MOTION_RST;
      cfg_r.max_motion   <= MAX_MOTION_RST;
      cfg_r.dup_epsilon  <= '0;
      cfg_r.min_interval <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_MIN_ANGLES:   prdata = cfg_r.min_angles;
      REG_MAX_ANGLES:   prdata = cfg_r.max_angles;
      REG_MIN_MOTION:   prdata = {{(DATA_W-MOTION_W){1'b0}}, cfg_r.min_motion};
      REG_MAX_MOTION:   prdata = {{(DATA_W-MOTION_W){1'b0}}, cfg_r.max_motion};
      REG_DUP_EPSILON:  prdata = {{(DATA_W-ANGLE_W){1'b0}}, cfg_r.dup_epsilon};
      REG_MIN_INTERVAL: prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_r.min_interval};
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;
endmodule
`default_nettype wire

FILE: hdl/jcsg_checker.sv
// Combinational check chain: angle window, duration, duplicate, rate, link.
`default_nettype none
module jcsg_checker (
  input  wire jcsg_pkg::cfg_t    cfg,
  input  wire jcsg_pkg::cmd_t    cmd,
  input  wire jcsg_pkg::hist_t   hist,
  output jcsg_pkg::status_t status
);
  import jcsg_pkg::*;

  logic angle_ok, dur_ok, dup, rate_bad;
  logic [JOINTS-1:0] lane_ok, lane_close;
  logic signed [ANGLE_W:0] diff [JOINTS];
  logic [ANGLE_W:0] mag [JOINTS];
  logic [TICK_W-1:0] elapsed;

  // Per-joint window and closeness, all lanes in parallel
  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      lane_ok[j] = (lane(cmd.angles, j) >= lane(cfg.min_angles, j)) &&
                   (lane(cmd.angles, j) <= lane(cfg.max_angles, j));
      // sign-extended 17-bit difference, exact for any pair of angles
      diff[j] = {cmd.angles[j*ANGLE_W + ANGLE_W-1], cmd.angles[j*ANGLE_W +: ANGLE_W]} -
                {hist.angles[j*ANGLE_W + ANGLE_W-1], hist.angles[j*ANGLE_W +: ANGLE_W]};
      mag[j]  = diff[j][ANGLE_W] ? -diff[j] : diff[j];
      lane_close[j] = (mag[j] <= {1'b0, cfg.dup_epsilon});
    end
  end

  assign angle_ok = &lane_ok;
  assign dur_ok   = (cmd.motion >= cfg.min_motion) && (cmd.motion <= cfg.max_motion);
  assign dup      = hist.has_last && (cmd.motion == hist.motion) && (&lane_close);
  // wrapping tick distance since the last accepted command
  assign elapsed  = cmd.now - hist.last_time;
  assign rate_bad = hist.has_last && (elapsed < cfg.min_interval);

  // First failing check wins
  always_comb begin
    if (!angle_ok)            status = ST_BAD_ANGLE;
    else if (!dur_ok)         status = ST_BAD_DURATION;
    else if (dup)             status = ST_DUPLICATE;
    else if (rate_bad)        status = ST_RATE;
    else if (!cmd.link_ready) status = ST_LINK;
    else                      status = ST_ACCEPTED;
  end
endmodule
`default_nettype wire

FILE: hdl/jcsg_history.sv
// Last accepted command and the four wrapping transaction counters.
`default_nettype none
module jcsg_history (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         update,
  input  wire jcsg_pkg::status_t status,
  input  wire jcsg_pkg::cmd_t    cmd,
  output jcsg_pkg::hist_t   hist,
  output jcsg_pkg::counts_t counts
);
  import jcsg_pkg::*;

  hist_t   hist_r, hist_nxt;
  counts_t counts_r, counts_nxt;

  // Store on accept, count every evaluated command
  always_comb begin
    hist_nxt   = hist_r;
    counts_nxt = counts_r;
    if (update) begin
      counts_nxt.attempted = counts_r.attempted + 1'b1;
      if (status == ST_ACCEPTED) begin
        hist_nxt.has_last  = 1'b1;
        hist_nxt.angles    = cmd.angles;
        hist_nxt.motion    = cmd.motion;
        hist_nxt.last_time = cmd.now;
        counts_nxt.accepted = counts_r.accepted + 1'b1;
      end else begin
        counts_nxt.rejected = counts_r.rejected + 1'b1;
        if (status == ST_LINK) counts_nxt.link_fail = counts_r.link_fail + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= '0;
      counts_r <= '0;
    end else begin
      hist_r   <= hist_nxt;
      counts_r <= counts_nxt;
    end
  end

  assign hist   = hist_r;
  assign counts = counts_r;
endmodule
`default_nettype wire

FILE: hdl/joint_command_safety_gate.sv
// Latency: results pass through the input register and then the result register.
// Throughput: 1 command per cycle while out_stall is low; check chain and history keep pace.
// The result register is freed in the cycle it is taken, so stalls back up one stage at a time.
// Reset (synchronous, rst_n low): limits to full range, history and counters cleared,
// pipeline emptied.
`default_nettype none
module joint_command_safety_gate (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [jcsg_pkg::PACK_W-1:0]   in_angles_packed,
  input  wire logic [jcsg_pkg::MOTION_W-1:0] in_motion_ms,
  input  wire logic [jcsg_pkg::TICK_W-1:0]   in_now_ticks,
  input  wire logic                          in_link_ready,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_status,
  output logic                               out_forward,
  output logic [jcsg_pkg::COUNT_W-1:0]       out_attempted_count,
  output logic [jcsg_pkg::COUNT_W-1:0]       out_accepted_count,
  output logic [jcsg_pkg::COUNT_W-1:0]       out_rejected_count,
  output logic [jcsg_pkg::COUNT_W-1:0]       out_link_fail_count,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [jcsg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [jcsg_pkg::DATA_W-1:0]   pwdata,
  output logic      [jcsg_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  import jcsg_pkg::*;

  cfg_t    cfg;
  hist_t   hist;
  counts_t counts;
  status_t status;

  cmd_t    cmd_r;
  logic    v1_r, v1_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r;
  logic    adv, in_take;

  // Stage handoff
  assign adv      = v1_r && (!out_valid_r || !out_stall);
  assign in_stall = v1_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign v1_nxt   = in_stall ? v1_r : in_valid;
  assign out_valid_nxt = adv ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r.angles     <= in_angles_packed;
      cmd_r.motion     <= in_motion_ms;
      cmd_r.now        <= in_now_ticks;
      cmd_r.link_ready <= in_link_ready;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv) out_status_r <= status;
  end

  jcsg_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  jcsg_checker u_chk (.cfg(cfg), .cmd(cmd_r), .hist(hist), .status(status));

  // counters move only when the result register loads, so they pair with it
  jcsg_history u_hist (
    .clk(clk), .rst_n(rst_n), .update(adv), .status(status), .cmd(cmd_r),
    .hist(hist), .counts(counts)
  );

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_forward         = (out_status_r == ST_ACCEPTED);
  assign out_attempted_count = counts.attempted;
  assign out_accepted_count  = counts.accepted;
  assign out_rejected_count  = counts.rejected;
  assign out_link_fail_count = counts.link_fail;
endmodule
`default_nettype wire

FILE: hdl/jcsg_sva.sv
// Port-level assertions for the safety gate and their bind to the top level.
`default_nettype none
module jcsg_sva (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic        out_forward,
  input wire logic [31:0] out_attempted_count,
  input wire logic [31:0] out_accepted_count,
  input wire logic [31:0] out_rejected_count,
  input wire logic [31:0] out_link_fail_count
);
  import jcsg_pkg::*;

  // A stalled result keeps its status
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  // Forward flag matches an accepted status
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_forward == (out_status == ST_ACCEPTED)))
    else $error("forward does not match status");

  // Every attempt is either accepted or rejected
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_attempted_count == out_accepted_count + out_rejected_count)
    else $error("counter totals disagree");

  // A link failure is always also a rejection
  a_link: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(out_link_fail_count) |-> !$stable(out_rejected_count))
    else $error("link failure counted without rejection");
endmodule

bind joint_command_safety_gate jcsg_sva u_jcsg_sva (.*);
`default_nettype wire
